### rtl/bst_pkg.sv
`default_nettype none
package bst_pkg;
    localparam int unsigned DEPTH_DEF = 32;
    localparam int unsigned LEN_BITS_DEF = 32;

    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_SSTART = 3'd1;
    localparam logic [2:0] K_SBYTE = 3'd2;
    localparam logic [2:0] K_INT = 3'd3;
    localparam logic [2:0] K_LOPEN = 3'd4;
    localparam logic [2:0] K_DOPEN = 3'd5;
    localparam logic [2:0] K_CLOSE = 3'd6;
    localparam logic [2:0] K_ERR = 3'd7;

    localparam logic [3:0] E_NONE = 4'd0;
    localparam logic [3:0] E_EOF = 4'd1;
    localparam logic [3:0] E_STR = 4'd2;
    localparam logic [3:0] E_INT = 4'd3;
    localparam logic [3:0] E_LIST = 4'd4;
    localparam logic [3:0] E_DICT = 4'd5;
    localparam logic [3:0] E_KEY = 4'd6;
    localparam logic [3:0] E_INV = 4'd7;
    localparam logic [3:0] E_DEEP = 4'd8;

    typedef enum logic [2:0] {
        M_VALUE, M_LEN, M_STR, M_INT, M_DONE, M_ERR
    } t_mode;

    // Result item, packed as it leaves on the master side.
    typedef struct packed {
        logic        value_done;
        logic [3:0]  fault_code;
        logic        is_key;
        logic [5:0]  nest_level;
        logic [63:0] int_value;
        logic        string_final;
        logic [31:0] string_length;
        logic [7:0]  out_byte;
        logic [2:0]  event_kind;
    } t_token;
endpackage
`default_nettype wire

### rtl/bencode_stream_tokenizer.sv
`default_nettype none
// Streaming bencode tokenizer. One byte enters per item on the slave side
// (tdata is the byte, tlast marks the end of a buffer), and exactly one
// token per byte leaves on the master side through the output register,
// one byte per cycle sustained while the master side does not stall. Open
// lists and dicts live in a stack memory of MAX_DEPTH entries whose top is
// held in a register beside it: a push writes the old top into the memory,
// and the entry below the top is kept for the depth that the stack will
// have after that cycle (read from the memory, or the old top on a push),
// so a close always finds it ready and the memory port never stalls input.
// On a last byte the parse state returns to reset, with no clearing pass.
module bencode_stream_tokenizer
    import bst_pkg::*;
#(
    parameter int unsigned MAX_DEPTH   = DEPTH_DEF,
    parameter int unsigned LENGTH_BITS = LEN_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // in_byte
    input  wire logic         s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // event_kind[2:0], out_byte[10:3], string_length[42:11], string_final[43],
    // int_value[107:44], nest_level[113:108], is_key[114], fault_code[118:115],
    // value_done[119]
    output logic [119:0]      m_axis_tdata
);
    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Each stack entry: bit0 dict, bit1 value side.
    logic [1:0] r_mem [MAX_DEPTH];
    logic [1:0] r_rd;
    logic [1:0] r_top, n_top;
    logic [DW-1:0] r_depth, n_depth;
    t_mode r_mode, n_mode;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic r_skip, n_skip;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [63:0] r_iacc, n_iacc;
    logic r_started, n_started, r_neg, n_neg, r_zero, n_zero, r_dig, n_dig;
    logic r_err, n_err;
    t_token r_tok, n_tok;
    logic r_ov;

    logic w_in, w_out_free;
    logic w_push;
    logic [7:0] b;
    logic w_isd;
    logic [3:0] w_d;
    logic [LENGTH_BITS-1:0] w_lsat;
    logic [63:0] w_isat;

    assign w_out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = w_out_free;
    assign w_in = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_tok;
    assign b = s_axis_tdata;
    assign w_isd = (b >= "0") && (b <= "9");
    assign w_d = 4'(b - "0");

    bst_mulacc #(.W(LENGTH_BITS)) u_len (
        .i_acc(r_len), .i_digit(w_d), .i_lim({LENGTH_BITS{1'b1}}), .o_res(w_lsat));
    bst_mulacc #(.W(64)) u_int (
        .i_acc(r_iacc), .i_digit(w_d), .i_lim(64'h8000_0000_0000_0000), .o_res(w_isat));

    // The entry below the top is kept prefetched in r_rd.
    always_ff @(posedge i_clk) begin
        if (w_in && w_push && r_depth != '0) r_mem[AW'(r_depth - 1'b1)] <= r_top;
    end
    logic [DW-1:0] w_rd_depth;
    always_comb w_rd_depth = w_in ? n_depth : r_depth;
    always_ff @(posedge i_clk) begin
        if (w_in && w_push) r_rd <= r_top;
        else if (w_rd_depth >= DW'(2)) r_rd <= r_mem[AW'(w_rd_depth - DW'(2))];
    end

    function automatic logic key_of(logic [DW-1:0] d, logic [1:0] t);
        return (d != '0) && t[0] && !t[1];
    endfunction

    always_comb begin
        logic key_done;
        logic [LENGTH_BITS-1:0] rem1;
        logic [3:0] code;
        n_top = r_top; n_depth = r_depth; n_mode = r_mode;
        n_len = r_len; n_skip = r_skip; n_rem = r_rem; n_iacc = r_iacc;
        n_started = r_started; n_neg = r_neg; n_zero = r_zero; n_dig = r_dig;
        n_err = r_err; n_tok = '0; w_push = 1'b0;
        key_done = 1'b0; rem1 = r_rem - 1'b1; code = E_NONE;
        // key_done marks a value that ends with this byte.
        unique case (r_mode)
            M_VALUE: begin
                if (w_isd) begin
                    n_mode = M_LEN; n_len = LENGTH_BITS'(w_d); n_skip = 1'b0;
                end else if (b == "i") begin
                    n_mode = M_INT; n_iacc = '0;
                    n_started = 1'b0; n_neg = 1'b0; n_zero = 1'b0; n_dig = 1'b0;
                end else if (b == "l" || b == "d") begin
                    if (r_depth >= DW'(MAX_DEPTH)) code = E_DEEP;
                    else begin
                        n_tok.event_kind = (b == "l") ? K_LOPEN : K_DOPEN;
                        n_tok.nest_level = 6'(r_depth);
                        n_tok.is_key = key_of(r_depth, r_top);
                        n_top = {1'b0, b == "d"};
                        n_depth = r_depth + 1'b1; w_push = 1'b1;
                    end
                end else if (b == "e" && r_depth != '0 && r_top != 2'b11) begin
                    n_depth = r_depth - 1'b1; n_top = r_rd;
                    n_tok.event_kind = K_CLOSE;
                    n_tok.nest_level = 6'(n_depth);
                    n_tok.is_key = key_of(n_depth, r_rd);
                    key_done = 1'b1;
                end else code = E_INV;
            end
            M_LEN: begin
                if (b == ":") begin
                    n_tok.event_kind = K_SSTART;
                    n_tok.string_length = (r_len > LENGTH_BITS'(32'hFFFF_FFFF))
                        ? 32'hFFFF_FFFF : 32'(r_len);
                    n_tok.nest_level = 6'(r_depth);
                    n_tok.is_key = key_of(r_depth, r_top);
                    if (r_len == '0) begin
                        n_tok.string_final = 1'b1; key_done = 1'b1;
                    end else begin
                        n_rem = r_len; n_mode = M_STR;
                    end
                end else if (!r_skip && w_isd) n_len = w_lsat;
                else n_skip = 1'b1;
            end
            M_STR: begin
                n_tok.event_kind = K_SBYTE; n_tok.out_byte = b;
                n_tok.nest_level = 6'(r_depth);
                n_tok.is_key = key_of(r_depth, r_top);
                n_rem = rem1;
                if (rem1 == '0) begin
                    n_tok.string_final = 1'b1; key_done = 1'b1;
                end
            end
            M_INT: begin
                n_started = 1'b1;
                if (b == "e") begin
                    n_tok.event_kind = K_INT;
                    n_tok.int_value = r_neg ? (64'd0 - r_iacc)
                        : (r_iacc[63] ? 64'h7FFF_FFFF_FFFF_FFFF : r_iacc);
                    n_tok.nest_level = 6'(r_depth);
                    n_tok.is_key = key_of(r_depth, r_top);
                    key_done = 1'b1;
                end else if (!r_started) begin
                    if (b == "-") n_neg = 1'b1;
                    else if (b == "0") begin n_zero = 1'b1; n_dig = 1'b1; end
                    else if (w_isd) begin n_iacc = 64'(w_d); n_dig = 1'b1; end
                    else code = E_INT;
                end else if (r_zero) code = E_INT;
                else if (r_neg && !r_dig && b == "0") code = E_INT;
                else if (w_isd) begin n_iacc = w_isat; n_dig = 1'b1; end
                else code = E_INT;
            end
            M_DONE, M_ERR: ;
            default: ;
        endcase
        // Value completion; strings are the only legal dict keys.
        if (key_done) begin
            n_mode = M_VALUE;
            if (n_depth == '0) begin
                n_mode = M_DONE; n_tok.value_done = 1'b1;
            end else if (n_top[0]) begin
                if (!n_top[1]) begin
                    if (r_mode == M_INT || r_mode == M_VALUE) code = E_KEY;
                    else n_top[1] = 1'b1;
                end else n_top[1] = 1'b0;
            end
        end
        if (code != E_NONE) begin
            n_tok = '0; n_tok.event_kind = K_ERR; n_tok.fault_code = code;
            n_tok.nest_level = 6'(n_depth);
            n_tok.is_key = key_of(n_depth, n_top);
            n_err = 1'b1; n_mode = M_ERR;
        end
        if (s_axis_tlast) begin
            if (!n_err && n_mode != M_DONE) begin
                if (n_mode == M_LEN || n_mode == M_STR) code = E_STR;
                else if (n_mode == M_INT) code = E_INT;
                else if (n_depth == '0) code = E_EOF;
                else if (!n_top[0]) code = E_LIST;
                else if (n_top[1]) code = E_EOF;
                else code = E_DICT;
                n_tok = '0; n_tok.event_kind = K_ERR; n_tok.fault_code = code;
                n_tok.nest_level = 6'(n_depth);
                n_tok.is_key = key_of(n_depth, n_top);
            end
            n_mode = M_VALUE; n_depth = '0; n_len = '0; n_skip = 1'b0; n_rem = '0;
            n_iacc = '0; n_started = 1'b0; n_neg = 1'b0; n_zero = 1'b0; n_dig = 1'b0;
            n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_VALUE; r_depth <= '0; r_len <= '0; r_skip <= 1'b0;
            r_rem <= '0; r_iacc <= '0; r_started <= 1'b0; r_neg <= 1'b0;
            r_zero <= 1'b0; r_dig <= 1'b0; r_err <= 1'b0; r_ov <= 1'b0;
            r_top <= '0;
        end else begin
            if (w_in) begin
                r_mode <= n_mode; r_depth <= n_depth; r_len <= n_len;
                r_skip <= n_skip; r_rem <= n_rem; r_iacc <= n_iacc;
                r_started <= n_started; r_neg <= n_neg; r_zero <= n_zero;
                r_dig <= n_dig; r_err <= n_err; r_top <= n_top;
                r_tok <= n_tok;
            end
            if (w_in) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_DEPTH)) else $error("depth over limit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> $stable(r_tok)) else $error("token changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in && s_axis_tlast |=> r_depth == '0 && r_mode == M_VALUE)
        else $error("no rearm");
`endif
endmodule
`default_nettype wire

### rtl/bst_mulacc.sv
`default_nettype none
// Saturating decimal accumulate: acc*10+d, clamped to lim.
module bst_mulacc
    import bst_pkg::*;
#(
    parameter int unsigned W = 64
) (
    input  wire logic [W-1:0] i_acc,
    input  wire logic [3:0]   i_digit,
    input  wire logic [W-1:0] i_lim,
    output logic [W-1:0]      o_res
);
    logic [W+3:0] w_prod;
    always_comb begin
        w_prod = ({4'd0, i_acc} << 3) + ({4'd0, i_acc} << 1) + (W+4)'(i_digit);
        if (w_prod > {4'd0, i_lim}) o_res = i_lim;
        else o_res = w_prod[W-1:0];
    end
endmodule
`default_nettype wire

### tb/tb_bencode_stream_tokenizer.sv
`default_nettype none

// Checks the bencode tokenizer one byte per item. A token predictor tracks its own copy
// of the nesting stack and the parse mode, and every emitted token is compared field by
// field with the oldest predicted token. A short directed table comes first, then random
// buffers that are mostly well-formed values, with broken ones and noise mixed in.
module tb_bencode_stream_tokenizer;
    import bst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STACK_DEPTH = DEPTH_DEF;
    localparam int unsigned RUN_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_BYTES = 1600;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;

    bencode_stream_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Frame flags kept per open level of the predictor's nesting stack.
    localparam logic [1:0] LVL_DICT = 2'b01;
    localparam logic [1:0] LVL_VALSIDE = 2'b10;

    // Predictor state.
    t_mode       pm_mode;
    logic [1:0]  pm_stack [STACK_DEPTH];
    int unsigned pm_depth;
    logic [32:0] pm_len;
    logic        pm_len_skip;
    logic [32:0] pm_remaining;
    logic [63:0] pm_accum;
    logic        pm_started, pm_neg, pm_zero, pm_digit;
    logic        pm_err_latched;

    t_token      token_queue [$];
    int unsigned mismatches;
    int unsigned table_errors;
    int unsigned tokens_checked;
    int unsigned bytes_sent;
    int unsigned buffers_sent;
    int unsigned cycle_count;
    logic        quiet_tx;
    logic        quiet_rx;

    function automatic bit is_digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void put_byte(inout logic [7:0] q [$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    function automatic void predictor_clear();
        pm_mode = M_VALUE;
        pm_depth = 0;
        pm_len = '0;
        pm_len_skip = 1'b0;
        pm_remaining = '0;
        pm_accum = '0;
        {pm_started, pm_neg, pm_zero, pm_digit} = '0;
        pm_err_latched = 1'b0;
    endfunction

    function automatic logic at_key_slot();
        if (pm_depth == 0) begin
            return 1'b0;
        end
        return pm_stack[pm_depth-1][0] && !pm_stack[pm_depth-1][1];
    endfunction

    function automatic void raise_error(inout t_token t, input logic [3:0] code);
        t = '0;
        t.event_kind = K_ERR;
        t.nest_level = pm_depth[5:0];
        t.is_key = at_key_slot();
        t.fault_code = code;
        pm_err_latched = 1'b1;
        pm_mode = M_ERR;
    endfunction

    // A value just ended: advance the enclosing dict between key and value.
    function automatic void finish_value(inout t_token t, input bit was_string);
        pm_mode = M_VALUE;
        if (pm_depth == 0) begin
            pm_mode = M_DONE;
            t.value_done = 1'b1;
        end else if (pm_stack[pm_depth-1][0]) begin
            if (!pm_stack[pm_depth-1][1]) begin
                if (!was_string) begin
                    raise_error(t, E_KEY);
                end else begin
                    pm_stack[pm_depth-1][1] = 1'b1;
                end
            end else begin
                pm_stack[pm_depth-1][1] = 1'b0;
            end
        end
    endfunction

    // Saturating decimal step: returns lim when acc*10+d would pass it.
    function automatic logic [63:0] decimal_step(input logic [63:0] acc, input int unsigned d,
                                                 input logic [63:0] lim);
        if (acc > (lim - 64'(d)) / 10) begin
            return lim;
        end
        return acc * 10 + 64'(d);
    endfunction

    function automatic void emit_integer(inout t_token t);
        logic [63:0] v;
        v = pm_accum;
        if (pm_neg) begin
            v = -v;
        end else if (v > 64'h7FFF_FFFF_FFFF_FFFF) begin
            v = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        t.event_kind = K_INT;
        t.int_value = v;
        t.nest_level = pm_depth[5:0];
        t.is_key = at_key_slot();
        finish_value(t, 1'b0);
    endfunction

    function automatic t_token predict_token(input logic [7:0] b, input logic last);
        t_token      t;
        logic [3:0]  code;
        logic [63:0] acc;
        t = '0;
        case (pm_mode)
            M_VALUE: begin
                if (is_digit_byte(b)) begin
                    pm_mode = M_LEN;
                    pm_len = 33'(b - "0");
                    pm_len_skip = 1'b0;
                end else if (b == "i") begin
                    pm_mode = M_INT;
                    pm_accum = '0;
                    {pm_started, pm_neg, pm_zero, pm_digit} = '0;
                end else if (b == "l" || b == "d") begin
                    if (pm_depth >= STACK_DEPTH) begin
                        raise_error(t, E_DEEP);
                    end else begin
                        t.event_kind = (b == "l") ? K_LOPEN : K_DOPEN;
                        t.nest_level = pm_depth[5:0];
                        t.is_key = at_key_slot();
                        pm_stack[pm_depth] = (b == "d") ? LVL_DICT : 2'b00;
                        pm_depth++;
                    end
                end else if (b == "e" && pm_depth > 0
                             && pm_stack[pm_depth-1] != (LVL_DICT | LVL_VALSIDE)) begin
                    pm_depth--;
                    t.event_kind = K_CLOSE;
                    t.nest_level = pm_depth[5:0];
                    t.is_key = at_key_slot();
                    finish_value(t, 1'b0);
                end else begin
                    raise_error(t, E_INV);
                end
            end
            M_LEN: begin
                if (b == ":") begin
                    t.event_kind = K_SSTART;
                    t.string_length = pm_len[31:0];
                    t.nest_level = pm_depth[5:0];
                    t.is_key = at_key_slot();
                    if (pm_len == 0) begin
                        t.string_final = 1'b1;
                        finish_value(t, 1'b1);
                    end else begin
                        pm_remaining = pm_len;
                        pm_mode = M_STR;
                    end
                end else if (!pm_len_skip && is_digit_byte(b)) begin
                    acc = decimal_step(64'(pm_len), b - "0", 64'hFFFF_FFFF);
                    pm_len = acc[32:0];
                end else begin
                    pm_len_skip = 1'b1;
                end
            end
            M_STR: begin
                t.event_kind = K_SBYTE;
                t.out_byte = b;
                t.nest_level = pm_depth[5:0];
                t.is_key = at_key_slot();
                pm_remaining--;
                if (pm_remaining == 0) begin
                    t.string_final = 1'b1;
                    finish_value(t, 1'b1);
                end
            end
            M_INT: begin
                if (!pm_started) begin
                    pm_started = 1'b1;
                    if (b == "e") begin
                        emit_integer(t);
                    end else if (b == "-") begin
                        pm_neg = 1'b1;
                    end else if (b == "0") begin
                        pm_zero = 1'b1;
                        pm_digit = 1'b1;
                    end else if (is_digit_byte(b)) begin
                        pm_accum = 64'(b - "0");
                        pm_digit = 1'b1;
                    end else begin
                        raise_error(t, E_INT);
                    end
                end else begin
                    if (b == "e") begin
                        emit_integer(t);
                    end else if (pm_zero) begin
                        raise_error(t, E_INT);
                    end else if (pm_neg && !pm_digit && b == "0") begin
                        // Negative zero is rejected.
                        raise_error(t, E_INT);
                    end else if (is_digit_byte(b)) begin
                        pm_accum = decimal_step(pm_accum, b - "0", 64'h8000_0000_0000_0000);
                        pm_digit = 1'b1;
                    end else begin
                        raise_error(t, E_INT);
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            if (!pm_err_latched && pm_mode != M_DONE) begin
                if (pm_mode == M_LEN || pm_mode == M_STR) begin
                    code = E_STR;
                end else if (pm_mode == M_INT) begin
                    code = E_INT;
                end else if (pm_depth == 0) begin
                    code = E_EOF;
                end else if (!pm_stack[pm_depth-1][0]) begin
                    code = E_LIST;
                end else if (pm_stack[pm_depth-1][1]) begin
                    code = E_EOF;
                end else begin
                    code = E_DICT;
                end
                raise_error(t, code);
            end
            predictor_clear();
        end
        return t;
    endfunction

    // Sends one byte; the predicted token is queued as the byte is accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_token t_new;
        while (!quiet_tx && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        t_new = predict_token(b, last);
        token_queue.insert(token_queue.size(), t_new);
        bytes_sent++;
        if (last) begin
            buffers_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Random content generators: each appends one bencoded value, at times a malformed one, to a byte list.
    task automatic add_integer(inout logic [7:0] buf_q [$]);
        int unsigned n;
        put_byte(buf_q, "i");
        if ($urandom_range(2) == 0) begin
            put_byte(buf_q, "-");
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(19, 22) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            put_byte(buf_q, 8'("1") + 8'($urandom_range(8)));
        end
        if ($urandom_range(15) == 0) begin
            put_byte(buf_q, "0");
        end
        put_byte(buf_q, "e");
    endtask

    task automatic add_string(inout logic [7:0] buf_q [$]);
        int unsigned n;
        string       s;
        n = $urandom_range(0, 7);
        s.itoa(n);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(buf_q, s[i]);
        end
        put_byte(buf_q, ":");
        for (int i = 0; i < n; i++) begin
            put_byte(buf_q, 8'($urandom_range(255)));
        end
    endtask

    task automatic add_value(inout logic [7:0] buf_q [$], input int unsigned level);
        int unsigned sel;
        int unsigned n;
        sel = (level >= 5) ? $urandom_range(1) : $urandom_range(3);
        case (sel)
            0: add_integer(buf_q);
            1: add_string(buf_q);
            2: begin
                put_byte(buf_q, "l");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    add_value(buf_q, level + 1);
                end
                put_byte(buf_q, "e");
            end
            default: begin
                put_byte(buf_q, "d");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(19) == 0) begin
                        add_integer(buf_q);
                    end else begin
                        add_string(buf_q);
                    end
                    add_value(buf_q, level + 1);
                end
                put_byte(buf_q, "e");
            end
        endcase
    endtask

    // Output side: random backpressure and field-by-field checking.
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet_rx || ($urandom_range(99) >= 11);
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_token'(m_axis_tdata);
                tokens_checked++;
                if (token_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: unexpected token %h", m_axis_tdata);
                    end
                end else begin
                    want = token_queue.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: token %0d kind exp %0d got %0d, byte %h/%h,",
                                     tokens_checked, want.event_kind, got.event_kind,
                                     want.out_byte, got.out_byte);
                            $display("  len %0d/%0d fin %b/%b int %0d/%0d lvl %0d/%0d",
                                     want.string_length, got.string_length,
                                     want.string_final, got.string_final,
                                     $signed(want.int_value), $signed(got.int_value),
                                     want.nest_level, got.nest_level);
                            $display("  key %b/%b err %0d/%0d done %b/%b",
                                     want.is_key, got.is_key, want.fault_code,
                                     got.fault_code, want.value_done, got.value_done);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on total simulated cycles.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed table: each entry is one whole buffer.
    typedef struct {
        string       text;
        logic        checked;
        logic [2:0]  kind;
        logic [3:0]  code;
    } t_case;

    t_case cases [] = '{
        '{"i0e", 1'b0, K_NONE, E_NONE},
        '{"i-e", 1'b0, K_NONE, E_NONE},
        '{"ie", 1'b0, K_NONE, E_NONE},
        '{"i9223372036854775807e", 1'b0, K_NONE, E_NONE},
        '{"i-9223372036854775808e", 1'b0, K_NONE, E_NONE},
        '{"i99999999999999999999e", 1'b0, K_NONE, E_NONE},
        '{"i-99999999999999999999e", 1'b0, K_NONE, E_NONE},
        '{"i03", 1'b1, K_ERR, E_INT},
        '{"i-0", 1'b1, K_ERR, E_INT},
        '{"ix", 1'b1, K_ERR, E_INT},
        '{"0:", 1'b0, K_NONE, E_NONE},
        '{"3x7:abc", 1'b0, K_NONE, E_NONE},
        '{"99999999999:ab", 1'b1, K_ERR, E_STR},
        '{"4:ab", 1'b1, K_ERR, E_STR},
        '{"i12", 1'b1, K_ERR, E_INT},
        '{"l", 1'b1, K_ERR, E_LIST},
        '{"d", 1'b1, K_ERR, E_DICT},
        '{"d1:a", 1'b1, K_ERR, E_EOF},
        '{"d1:ae", 1'b1, K_ERR, E_INV},
        '{"di1e", 1'b1, K_ERR, E_KEY},
        '{"e", 1'b1, K_ERR, E_INV},
        '{"d1:ali1ei2eee", 1'b0, K_NONE, E_NONE},
        '{"i5ei6e", 1'b0, K_NONE, E_NONE},
        '{"", 1'b0, K_NONE, E_NONE}
    };

    initial begin
        logic [7:0]  buf_q [$];
        int unsigned sel;
        int unsigned depth;
        t_token      want;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        table_errors = 0;
        bytes_sent = 0;
        buffers_sent = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        predictor_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers. Where a row is marked checked, the final predicted token of that
        // buffer is compared to its kind as well (an error code of none is not compared).
        foreach (cases[c]) begin
            if (cases[c].text.len() == 0) begin
                // Nesting one past the stack limit, closed by a last byte.
                for (int i = 0; i <= STACK_DEPTH; i++) begin
                    send_byte((i % 2) ? "l" : "d", i == STACK_DEPTH);
                    if (i % 2 == 0 && i < STACK_DEPTH) begin
                        send_byte("1", 1'b0);
                        send_byte(":", 1'b0);
                        send_byte("k", 1'b0);
                    end
                end
                want = token_queue[$];
                if (want.fault_code != E_DEEP) begin
                    table_errors++;
                    $display("ERROR: depth limit not predicted as too deep");
                end
            end else begin
                send_text(cases[c].text);
                want = token_queue[$];
                if (cases[c].checked && (want.event_kind != cases[c].kind
                        || (cases[c].code != E_NONE && want.fault_code != cases[c].code))) begin
                    table_errors++;
                    $display("ERROR: directed buffer %s predicted kind %0d code %0d",
                             cases[c].text, want.event_kind, want.fault_code);
                end
            end
        end

        // Random buffers until the byte budget is spent.
        while (bytes_sent < RANDOM_BYTES) begin
            quiet_tx = (bytes_sent > 900 && bytes_sent < 1200);
            quiet_rx = quiet_tx;
            buf_q.delete();
            sel = $urandom_range(99);
            if (sel < 70) begin
                add_value(buf_q, 0);
            end else if (sel < 80) begin
                add_value(buf_q, 0);
                depth = $urandom_range(buf_q.size() - 1);
                while (buf_q.size() > depth + 1) begin
                    void'(buf_q.pop_back());
                end
            end else if (sel < 90) begin
                add_value(buf_q, 0);
                buf_q[$urandom_range(buf_q.size() - 1)] = 8'($urandom_range(255));
            end else begin
                depth = $urandom_range(1, 8);
                for (int i = 0; i < depth; i++) begin
                    put_byte(buf_q, 8'($urandom_range(255)));
                end
            end
            if ($urandom_range(7) == 0) begin
                put_byte(buf_q, 8'($urandom_range(255)));
            end
            for (int i = 0; i < buf_q.size(); i++) begin
                send_byte(buf_q[i], i == buf_q.size() - 1);
            end
        end
        s_axis_tvalid <= 1'b0;
        quiet_rx = 1'b1;

        while (token_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers; %0d tokens compared.",
                 bytes_sent, buffers_sent, tokens_checked);
        if (mismatches == 0 && table_errors == 0 && token_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Mismatches: %0d", mismatches + table_errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/bst_pkg.sv
rtl/bst_mulacc.sv
rtl/bencode_stream_tokenizer.sv
tb/tb_bencode_stream_tokenizer.sv
